FILE: hdl/xrg_pkg.sv
// Shared constants, state type and control and status structs of the xorshift128 range generator.
`default_nettype none

package xrg_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 23;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam int SHIFT_T_LEFT  = 11;
    localparam int SHIFT_T_RIGHT = 8;
    localparam int SHIFT_W_RIGHT = 19;

    localparam logic [WORD_W-1:0] SEED_MULT = 32'h6c07_8965;

    localparam logic [63:0] RESET_W2_WIDE = 64'h6c07_8965 * 64'd1 + 64'd1;
    localparam logic [63:0] RESET_W3_WIDE = 64'h6c07_8966 * 64'h6c07_8965 + 64'd1;

    localparam logic [WORD_W-1:0] RESET_W0 = 32'd0;
    localparam logic [WORD_W-1:0] RESET_W1 = 32'd1;
    localparam logic [WORD_W-1:0] RESET_W2 = RESET_W2_WIDE[WORD_W-1:0];
    localparam logic [WORD_W-1:0] RESET_W3 = RESET_W3_WIDE[WORD_W-1:0];

    localparam logic [1:0] SEED_STEPS = 2'd3;

    localparam logic FUNC_RAW   = 1'b0;
    localparam logic FUNC_RANGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    typedef struct packed {
        logic advance;
    } gen_ctrl_t;

    typedef struct packed {
        logic busy;
    } gen_stat_t;

endpackage

`default_nettype wire

FILE: hdl/xrg_if.sv
// Request and response channel interfaces of the xorshift128 range generator.
`default_nettype none

interface xrg_req_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic signed [xrg_pkg::WORD_W-1:0] range_low;
    logic signed [xrg_pkg::WORD_W-1:0] range_high;

    modport source (output valid, output func, output range_low, output range_high,
                    input ready);
    modport sink   (input valid, input func, input range_low, input range_high,
                    output ready);
endinterface

interface xrg_rsp_if;
    logic                             valid;
    logic                             ready;
    logic        [xrg_pkg::WORD_W-1:0] raw_word;
    logic        [xrg_pkg::FRAC_W-1:0] fraction;
    logic signed [xrg_pkg::WORD_W-1:0] ranged;
    logic                             advanced;

    modport source (output valid, output raw_word, output fraction, output ranged,
                    output advanced, input ready);
    modport sink   (input valid, input raw_word, input fraction, input ranged,
                    input advanced, output ready);
endinterface

`default_nettype wire

FILE: hdl/xrg_gen.sv
// Generator state words with serial re-seeding and the xorshift step.
`default_nettype none

module xrg_gen (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [xrg_pkg::WORD_W-1:0] cfg_data,
    input  wire xrg_pkg::gen_ctrl_t         ctrl,
    output xrg_pkg::gen_stat_t              stat,
    output logic      [xrg_pkg::WORD_W-1:0] new_word
);

    logic [xrg_pkg::WORD_W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [xrg_pkg::WORD_W-1:0] w0_next, w1_next, w2_next, w3_next;
    logic [1:0]                 seed_cnt_reg, seed_cnt_next;
    logic [xrg_pkg::WORD_W-1:0] t_word;
    logic [xrg_pkg::WORD_W-1:0] seed_prod;

    assign t_word    = w0_reg ^ (w0_reg << xrg_pkg::SHIFT_T_LEFT);
    assign new_word  = w3_reg ^ (w3_reg >> xrg_pkg::SHIFT_W_RIGHT)
                     ^ t_word ^ (t_word >> xrg_pkg::SHIFT_T_RIGHT);
    assign seed_prod = w3_reg * xrg_pkg::SEED_MULT + xrg_pkg::WORD_W'(1);

    assign stat.busy = (seed_cnt_reg != 2'd0);

    always_comb
    begin
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        w3_next       = w3_reg;
        seed_cnt_next = seed_cnt_reg;
        if (cfg_we)
        begin
            w3_next       = cfg_data;
            seed_cnt_next = xrg_pkg::SEED_STEPS;
        end
        else if (seed_cnt_reg != 2'd0)
        begin
            w0_next       = w1_reg;
            w1_next       = w2_reg;
            w2_next       = w3_reg;
            w3_next       = seed_prod;
            seed_cnt_next = seed_cnt_reg - 2'd1;
        end
        else if (ctrl.advance)
        begin
            w0_next = w1_reg;
            w1_next = w2_reg;
            w2_next = w3_reg;
            w3_next = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg       <= xrg_pkg::RESET_W0;
            w1_reg       <= xrg_pkg::RESET_W1;
            w2_reg       <= xrg_pkg::RESET_W2;
            w3_reg       <= xrg_pkg::RESET_W3;
            seed_cnt_reg <= 2'd0;
        end
        else
        begin
            w0_reg       <= w0_next;
            w1_reg       <= w1_next;
            w2_reg       <= w2_next;
            w3_reg       <= w3_next;
            seed_cnt_reg <= seed_cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/xrg_mod.sv
// Bit-serial restoring modulo unit, one dividend bit per cycle.
`default_nettype none

module xrg_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire xrg_pkg::mod_ctrl_t         ctrl,
    input  wire logic [xrg_pkg::WORD_W-1:0] dividend,
    input  wire logic [xrg_pkg::WORD_W-1:0] divisor,
    output xrg_pkg::mod_stat_t              stat,
    output logic      [xrg_pkg::WORD_W-1:0] remainder
);

    localparam logic [xrg_pkg::CNT_W-1:0] LAST_BIT = xrg_pkg::CNT_W'(xrg_pkg::WORD_W - 1);

    logic [xrg_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [xrg_pkg::WORD_W-1:0] dvd_reg, dvd_next;
    logic [xrg_pkg::WORD_W-1:0] dvs_reg, dvs_next;
    logic [xrg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [xrg_pkg::WORD_W:0]   trial;
    logic [xrg_pkg::WORD_W:0]   trial_sub;
    logic                       fits;

    assign trial     = {rem_reg, dvd_reg[xrg_pkg::WORD_W-1]};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[xrg_pkg::WORD_W-1:0] : trial[xrg_pkg::WORD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + xrg_pkg::CNT_W'(1);
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

FILE: hdl/xorshift128_range_generator.sv
// Top level of the xorshift128 range generator: request control and response register.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+------------------------------------------
//  cfg     | in  | cfg_we                | cfg_data: seed
//  req     | in  | req.valid & req.ready | func, range_low, range_high
//  rsp     | out | rsp.valid & rsp.ready | raw_word, fraction, ranged, advanced
//
//  Raw draw and equal-bound draw: the request passes through ST_PREP and ST_DONE into the response register.
//  Range draw: adds ST_DIV for the bit-serial modulo unit (one bit per cycle).
//  A seed write holds req.ready low while cfg_we is high and while the state words fill.
//  Reset loads the state words seeded from zero; no clearing pass.
//  A stalled response holds in the response register; the next word is taken meanwhile.
`default_nettype none

module xorshift128_range_generator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [xrg_pkg::WORD_W-1:0] cfg_data,
    xrg_req_if.sink                         req,
    xrg_rsp_if.source                       rsp
);

    xrg_pkg::state_t state_reg, state_next;

    xrg_pkg::gen_ctrl_t gen_ctrl;
    xrg_pkg::gen_stat_t gen_stat;
    xrg_pkg::mod_ctrl_t mod_ctrl;
    xrg_pkg::mod_stat_t mod_stat;

    logic [xrg_pkg::WORD_W-1:0] new_word;
    logic [xrg_pkg::WORD_W-1:0] remainder;

    logic                       func_reg, func_next;
    logic [xrg_pkg::WORD_W-1:0] lo_reg, lo_next;
    logic [xrg_pkg::WORD_W-1:0] hi_reg, hi_next;
    logic [xrg_pkg::WORD_W-1:0] raw_reg, raw_next;
    logic [xrg_pkg::WORD_W-1:0] rng_reg, rng_next;
    logic                       adv_reg, adv_next;

    logic [xrg_pkg::WORD_W-1:0] out_raw_reg, out_raw_next;
    logic [xrg_pkg::WORD_W-1:0] out_rng_reg, out_rng_next;
    logic                       out_adv_reg, out_adv_next;
    logic                       out_valid_reg, out_valid_next;

    logic                       swap;
    logic [xrg_pkg::WORD_W-1:0] lo_ord;
    logic [xrg_pkg::WORD_W-1:0] hi_ord;
    logic [xrg_pkg::WORD_W-1:0] diff;
    logic                       step;
    logic                       need_mod;
    logic                       accept;
    logic                       out_load;

    assign swap     = ($signed(lo_reg) > $signed(hi_reg));
    assign lo_ord   = swap ? hi_reg : lo_reg;
    assign hi_ord   = swap ? lo_reg : hi_reg;
    assign diff     = hi_ord - lo_ord;
    assign need_mod = (func_reg == xrg_pkg::FUNC_RANGE) && (diff != '0);
    assign step     = (func_reg == xrg_pkg::FUNC_RAW) || need_mod;
    assign accept   = req.valid && req.ready;

    xrg_gen u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ctrl     (gen_ctrl),
        .stat     (gen_stat),
        .new_word (new_word)
    );

    xrg_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mod_ctrl),
        .dividend  (new_word),
        .divisor   (diff),
        .stat      (mod_stat),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xrg_pkg::ST_IDLE:
                if (accept)
                    state_next = xrg_pkg::ST_PREP;
            xrg_pkg::ST_PREP:
                state_next = need_mod ? xrg_pkg::ST_DIV : xrg_pkg::ST_DONE;
            xrg_pkg::ST_DIV:
                if (mod_stat.done)
                    state_next = xrg_pkg::ST_DONE;
            xrg_pkg::ST_DONE:
                if (!out_valid_reg || rsp.ready)
                    state_next = xrg_pkg::ST_IDLE;
            default:
                state_next = xrg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready        = 1'b0;
        gen_ctrl.advance = 1'b0;
        mod_ctrl.start   = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            xrg_pkg::ST_IDLE:
                req.ready = !gen_stat.busy && !cfg_we;
            xrg_pkg::ST_PREP:
            begin
                gen_ctrl.advance = step;
                mod_ctrl.start   = need_mod;
            end
            xrg_pkg::ST_DIV:
                ;
            xrg_pkg::ST_DONE:
                out_load = !out_valid_reg || rsp.ready;
            default:
                ;
        endcase
    end

    always_comb
    begin
        func_next = func_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        raw_next  = raw_reg;
        rng_next  = rng_reg;
        adv_next  = adv_reg;
        if (accept)
        begin
            func_next = req.func;
            lo_next   = req.range_low;
            hi_next   = req.range_high;
        end
        if (state_reg == xrg_pkg::ST_PREP)
        begin
            lo_next  = lo_ord;
            raw_next = step ? new_word : '0;
            adv_next = step;
            rng_next = (func_reg == xrg_pkg::FUNC_RANGE) ? lo_ord : '0;
        end
        if ((state_reg == xrg_pkg::ST_DIV) && mod_stat.done)
            rng_next = lo_reg + remainder;
    end

    always_comb
    begin
        out_raw_next   = out_raw_reg;
        out_rng_next   = out_rng_reg;
        out_adv_next   = out_adv_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
        begin
            out_raw_next   = raw_reg;
            out_rng_next   = rng_reg;
            out_adv_next   = adv_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xrg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        raw_reg     <= raw_next;
        rng_reg     <= rng_next;
        adv_reg     <= adv_next;
        out_raw_reg <= out_raw_next;
        out_rng_reg <= out_rng_next;
        out_adv_reg <= out_adv_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.raw_word = out_raw_reg;
    assign rsp.fraction = out_raw_reg[xrg_pkg::FRAC_W-1:0];
    assign rsp.ranged   = out_rng_reg;
    assign rsp.advanced = out_adv_reg;

    a_mod_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.busy |-> (state_reg == xrg_pkg::ST_DIV))
        else $error("modulo unit busy outside the divide state");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("response register overwritten while still pending");

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        mod_ctrl.start |=> (state_reg == xrg_pkg::ST_DIV) && mod_stat.busy)
        else $error("divide did not start after request preparation");

    a_no_step_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.advanced) |-> (rsp.raw_word == '0))
        else $error("raw word nonzero on a response without a step");

endmodule

`default_nettype wire

FILE: tb/xorshift128_range_generator_tb.sv
// Self-checking testbench of the xorshift128 range generator: seeded draws against a predictor.
`timescale 1ns / 1ps

module xorshift128_range_generator_tb;

    import xrg_pkg::*;

    localparam int              PHASES         = 7;
    localparam int              ITEMS_PER_PASS = 270;
    localparam int unsigned     CYCLE_LIMIT    = 1_000_000;
    localparam int              DRAIN_CYCLES   = 40;
    localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     func;
        logic signed [WORD_W-1:0] range_low;
        logic signed [WORD_W-1:0] range_high;
    } draw_req_t;

    typedef struct packed {
        logic        [WORD_W-1:0] raw_word;
        logic        [FRAC_W-1:0] fraction;
        logic signed [WORD_W-1:0] ranged;
        logic                     advanced;
    } draw_rsp_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [WORD_W-1:0] cfg_data;

    xrg_req_if req_ch ();
    xrg_rsp_if rsp_ch ();

    xorshift128_range_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    logic [WORD_W-1:0] state_words [4];
    draw_req_t         pending_reqs [$];
    draw_rsp_t         expected_draws [$];
    logic              req_taken;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                failures;
    int unsigned       cycle_count;
    int                send_idle_mode [4] = '{0, 72, 0, 19};
    int                recv_stall_mode [4] = '{0, 0, 72, 19};

    function automatic void reseed_words(logic [WORD_W-1:0] seed_val);
        state_words[0] = seed_val;
        for (int i = 1; i < 4; i++)
        begin
            state_words[i] = state_words[i-1] * SEED_MULT + 32'd1;
        end
    endfunction

    function automatic logic [WORD_W-1:0] step_words();
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] n;
        t = state_words[0] ^ (state_words[0] << SHIFT_T_LEFT);
        w = state_words[3];
        n = w ^ (w >> SHIFT_W_RIGHT) ^ t ^ (t >> SHIFT_T_RIGHT);
        state_words[0] = state_words[1];
        state_words[1] = state_words[2];
        state_words[2] = w;
        state_words[3] = n;
        return n;
    endfunction

    function automatic draw_rsp_t predict_draw(draw_req_t r);
        draw_rsp_t         res;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] span;
        res = '0;
        lo  = r.range_low;
        hi  = r.range_high;
        if (r.func == FUNC_RAW)
        begin
            res.raw_word = step_words();
            res.advanced = 1'b1;
        end
        else
        begin
            if ($signed(r.range_low) > $signed(r.range_high))
            begin
                lo = r.range_high;
                hi = r.range_low;
            end
            span = hi - lo;
            if (span != '0)
            begin
                res.raw_word = step_words();
                res.advanced = 1'b1;
                res.ranged   = lo + (res.raw_word % span);
            end
            else
            begin
                res.ranged = lo;
            end
        end
        res.fraction = res.raw_word[FRAC_W-1:0];
        return res;
    endfunction

    function automatic draw_req_t random_draw_req();
        draw_req_t r;
        int        shape;
        r.func       = 1'($urandom_range(1));
        r.range_low  = $urandom;
        r.range_high = $urandom;
        shape        = $urandom_range(9);
        if (shape == 0)
        begin
            r.range_high = r.range_low;
        end
        else if (shape <= 3)
        begin
            r.range_high = r.range_low + $urandom_range(1, 40);
        end
        else if (shape == 4)
        begin
            r.range_high = r.range_low + (32'd1 << $urandom_range(31));
        end
        if (shape >= 1 && shape <= 4 && $urandom_range(1) == 1)
        begin
            r = '{r.func, r.range_high, r.range_low};
        end
        return r;
    endfunction

    task automatic queue_draw(logic func, logic signed [WORD_W-1:0] lo,
                              logic signed [WORD_W-1:0] hi);
        pending_reqs.push_back('{func, lo, hi});
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_draws.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_seed(logic [WORD_W-1:0] seed_val);
        cfg_data <= seed_val;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    draw_req_t item;
                    item = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.func       <= item.func;
                    req_ch.range_low  <= item.range_low;
                    req_ch.range_high <= item.range_high;
                end
                else
                begin
                    req_ch.valid      <= 1'b0;
                    req_ch.func       <= 1'($urandom_range(1));
                    req_ch.range_low  <= $urandom;
                    req_ch.range_high <= $urandom;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            reseed_words('0);
        end
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (cfg_we)
            begin
                reseed_words(cfg_data);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_draws.push_back(predict_draw('{req_ch.func, req_ch.range_low,
                                                        req_ch.range_high}));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("unexpected response word: raw_word %h ranged %h",
                           rsp_ch.raw_word, rsp_ch.ranged);
                    failures++;
                end
                else
                begin
                    draw_rsp_t exp_rsp;
                    exp_rsp = expected_draws.pop_front();
                    if (rsp_ch.raw_word !== exp_rsp.raw_word)
                    begin
                        $error("raw_word: expected %h, actual %h",
                               exp_rsp.raw_word, rsp_ch.raw_word);
                        failures++;
                    end
                    if (rsp_ch.fraction !== exp_rsp.fraction)
                    begin
                        $error("fraction: expected %h, actual %h",
                               exp_rsp.fraction, rsp_ch.fraction);
                        failures++;
                    end
                    if (rsp_ch.ranged !== exp_rsp.ranged)
                    begin
                        $error("ranged: expected %h, actual %h",
                               exp_rsp.ranged, rsp_ch.ranged);
                        failures++;
                    end
                    if (rsp_ch.advanced !== exp_rsp.advanced)
                    begin
                        $error("advanced: expected %b, actual %b",
                               exp_rsp.advanced, rsp_ch.advanced);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] phase_seeds [PHASES];
        phase_seeds[1] = 32'h7FFF_FFFF;
        phase_seeds[2] = 32'h8000_0000;
        phase_seeds[3] = 32'hFFFF_FFFF;
        phase_seeds[4] = 32'h0000_0000;
        phase_seeds[5] = $urandom;
        phase_seeds[6] = $urandom;
        failures          = 0;
        cycle_count       = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_RAW;
        req_ch.range_low  = '0;
        req_ch.range_high = '0;
        rsp_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_draw(FUNC_RAW,   32'sd0,    32'sd0);
        queue_draw(FUNC_RAW,   INT_MAX,   INT_MIN);
        queue_draw(FUNC_RANGE, INT_MIN,   INT_MAX);
        queue_draw(FUNC_RANGE, INT_MAX,   INT_MIN);
        queue_draw(FUNC_RANGE, 32'sd0,    32'sd0);
        queue_draw(FUNC_RANGE, INT_MIN,   INT_MIN);
        queue_draw(FUNC_RANGE, INT_MAX,   INT_MAX);
        queue_draw(FUNC_RANGE, 32'sd0,    32'sd1);
        queue_draw(FUNC_RANGE, 32'sd1,    32'sd0);
        queue_draw(FUNC_RANGE, -32'sd1,   32'sd1);
        queue_draw(FUNC_RANGE, INT_MIN,   INT_MIN + 1);
        queue_draw(FUNC_RANGE, INT_MAX - 1, INT_MAX);
        queue_draw(FUNC_RANGE, 32'sd5,    -32'sd3);
        queue_draw(FUNC_RANGE, 32'sd0,    INT_MAX);
        queue_draw(FUNC_RANGE, INT_MIN,   32'sd0);
        queue_draw(FUNC_RANGE, -32'sd100, 32'sd100);
        queue_draw(FUNC_RANGE, 32'sd0,    32'sh0001_0000);
        queue_draw(FUNC_RANGE, -32'sd1,   -32'sd1);
        queue_draw(FUNC_RAW,   -32'sd1,   -32'sd1);
        queue_draw(FUNC_RAW,   32'sd0,    32'sd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                write_seed(phase_seeds[ph]);
            end
            send_idle_pct  = send_idle_mode[ph % 4];
            recv_stall_pct = recv_stall_mode[ph % 4];
            for (int i = 0; i < ITEMS_PER_PASS; i++)
            begin
                pending_reqs.push_back(random_draw_req());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && expected_draws.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
